// ----- rtl/pomr_pkg.sv -----
// Shared types and constants for the packet offset match and rewrite block.
// Depends on nothing; the top level and the checker import it.
package pomr_pkg;

   localparam int CMD_W      = 3;
   localparam int FIDX_W     = 4;
   localparam int OFF_W      = 16;
   localparam int VAL_W      = 8;
   localparam int LEN_W      = 12;
   localparam int FUNC_W     = 16;
   localparam int ACT_W      = 4;
   localparam int CSR_W      = 5;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 16;
   localparam int REL_BIAS   = 250;

   typedef enum logic [CMD_W-1:0] {
      CMD_HEADER  = 3'd0,
      CMD_ADD_SRC = 3'd1,
      CMD_ADD_REP = 3'd2,
      CMD_WRITE   = 3'd3,
      CMD_APPLY   = 3'd4,
      CMD_CHECK   = 3'd5,
      CMD_READ    = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_FIXED   = 2'd0,
      MODE_OCC_ABS = 2'd1,
      MODE_OCC_REL = 2'd2,
      MODE_BAD     = 2'd3
   } mode_type;

   typedef struct packed {
      logic              enabled;
      mode_type          mode;
      logic [FUNC_W-1:0] func;
      logic [ACT_W-1:0]  actions;
      logic [OFF_W-1:0]  len_min;
      logic [OFF_W-1:0]  len_max;
   } hdr_type;

   localparam int HDR_W = $bits(hdr_type);

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000000000000001,
      ST_DISPATCH = 15'b000000000000010,
      ST_ADD_RD   = 15'b000000000000100,
      ST_ADD_SCAN = 15'b000000000001000,
      ST_ADD_CHK  = 15'b000000000010000,
      ST_BYTE_RD  = 15'b000000000100000,
      ST_WALK     = 15'b000000001000000,
      ST_WALK_RD  = 15'b000000010000000,
      ST_EVAL     = 15'b000000100000000,
      ST_S_RD     = 15'b000001000000000,
      ST_S_PKT    = 15'b000010000000000,
      ST_S_CMP    = 15'b000100000000000,
      ST_R_RD     = 15'b001000000000000,
      ST_R_WR     = 15'b010000000000000,
      ST_DONE     = 15'b100000000000000
   } state_type;

endpackage

// ----- rtl/pomr_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; used for the packet, entry and filter stores.
module pomr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/packet_offset_match_rewrite.sv -----
// Top level of the packet offset match and rewrite engine: handshake, sequencer.
// Depends on pomr_pkg and pomr_ram.
//
//  channel | dir | beat fields
//  --------+-----+----------------------------------------------------------
//  req_    | in  | tuser: cmd; tdata: filter_index .. length (one command)
//  rsp_    | out | tdata: read_value, modified, action_hit, rejected
//  csr_    | in  | active_filters, written with csr_we
//
//  One command at a time. A read adds a packet read to the header, write and
//  unused command path; an add walks its list one stored entry at a time. Apply
//  and check walk the filter table slot by slot; every compared search byte
//  takes an entry read, a packet read and a compare, and every replace byte an
//  entry read and a write, since each store has a single registered read port.
//  Reset clears control state and the filter valid bits; no clearing pass.
//  A finished result waits in the rsp_ register; a new beat is taken meanwhile.
module packet_offset_match_rewrite
   import pomr_pkg::*;
#(
   parameter int NUM_FILTERS = 16,
   parameter int MAX_PACKET  = 2048,
   parameter int MAX_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cmd
   input  logic [CMD_W-1:0]      req_tuser,
   // filter_index, enabled, mode, func_bits, action_bits, len_min, len_max,
   // offset, value, length, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // read_value, modified, action_hit, rejected, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int FW   = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
   localparam int SW   = $clog2(NUM_FILTERS + 1);
   localparam int LW   = (SW > CSR_W) ? SW : CSR_W;
   localparam int EW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int PW   = $clog2(MAX_PACKET);
   localparam int FT_W = HDR_W + OFF_W + 2 * CW;
   localparam int EN_W = OFF_W + VAL_W;
   localparam int IW   = OFF_W + 1;

   // Request fields, lowest bit first.
   logic [FIDX_W-1:0] f_fi;
   logic              f_en;
   logic [1:0]        f_mode;
   logic [FUNC_W-1:0] f_func;
   logic [ACT_W-1:0]  f_act;
   logic [OFF_W-1:0]  f_lmin, f_lmax, f_off;
   logic [VAL_W-1:0]  f_val;
   logic [LEN_W-1:0]  f_len;

   assign f_fi   = req_tdata[3:0];
   assign f_en   = req_tdata[4];
   assign f_mode = req_tdata[6:5];
   assign f_func = req_tdata[22:7];
   assign f_act  = req_tdata[26:23];
   assign f_lmin = req_tdata[42:27];
   assign f_lmax = req_tdata[58:43];
   assign f_off  = req_tdata[74:59];
   assign f_val  = req_tdata[82:75];
   assign f_len  = req_tdata[94:83];

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [FIDX_W-1:0] fi_ff, fi_in;
   hdr_type           nhdr_ff, nhdr_in;      // header carried by the command
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CSR_W-1:0]  active_ff, active_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [VAL_W-1:0]  sval_ff, sval_in;
   logic              inr_ff, inr_in;
   hdr_type           fhdr_ff, fhdr_in;      // header of the slot being worked
   logic [OFF_W-1:0]  fmax_ff, fmax_in;
   logic [CW-1:0]     fnsrc_ff, fnsrc_in, fnrep_ff, fnrep_in;
   logic [VAL_W-1:0]  rd_ff, rd_in;
   logic              mod_ff, mod_in, hit_ff, hit_in, rej_ff, rej_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [2**FW-1:0]  fvalid_ff, fvalid_in;
   logic              ft_rvalid_ff;

   // Store ports.
   logic              ft_we;
   logic [FT_W-1:0]   ft_wdata, ft_rdata, ft_rd;
   logic              src_we, rep_we, pkt_we;
   logic [EN_W-1:0]   ent_wdata, src_rdata, rep_rdata;
   logic [FW+EW-1:0]  ent_waddr, ent_raddr;
   logic [PW-1:0]     pkt_waddr, pkt_raddr;
   logic [VAL_W-1:0]  pkt_wdata, pkt_rdata;

   // Datapath helpers.
   logic              accept, fi_ok, off_ok, act_ok, qual, skip;
   logic [CW-1:0]     cnt;
   logic [OFF_W-1:0]  chk_off, new_max;
   logic [IW-1:0]     sidx, ridx, rsum, last_pos;
   logic              rel_ok;
   logic [LW-1:0]     act_ext, lim;
   logic [VAL_W-1:0]  pkt_byte;
   logic [OFF_W-1:0]  len16;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign fi_ok  = 32'(fi_ff) < NUM_FILTERS;
   assign off_ok = 32'(off_ff) < MAX_PACKET;
   assign act_ok = (nhdr_ff.actions != '0) &&
                   ((nhdr_ff.actions & (nhdr_ff.actions - 1'b1)) == '0);
   assign act_ext = LW'(active_ff);
   assign lim     = (act_ext > LW'(NUM_FILTERS)) ? LW'(NUM_FILTERS) : act_ext;
   assign len16   = OFF_W'(len_ff);

   // An unwritten slot reads as all zero.
   assign ft_rd = ft_rvalid_ff ? ft_rdata : '0;

   // Qualification of the slot held in the working registers.
   assign qual = fhdr_ff.enabled &&
                 ((fhdr_ff.len_max == '0) ||
                  ((len16 >= fhdr_ff.len_min) && (len16 <= fhdr_ff.len_max))) &&
                 ((fhdr_ff.func & nhdr_ff.func) != '0) &&
                 ((fnsrc_ff == '0) || (fmax_ff < len16));
   assign skip = (cmd_ff == CMD_APPLY) ? ((fnrep_ff == '0) || !qual)
               : (((fhdr_ff.actions & nhdr_ff.actions) == '0) ||
                  (fnsrc_ff == '0) || !qual);

   assign cnt     = (cmd_ff == CMD_ADD_SRC) ? fnsrc_ff : fnrep_ff;
   assign chk_off = (cmd_ff == CMD_ADD_SRC) ? src_rdata[OFF_W-1:0]
                                            : rep_rdata[OFF_W-1:0];
   assign new_max = (off_ff > fmax_ff) ? off_ff : fmax_ff;

   assign sidx     = IW'(src_rdata[OFF_W-1:0]) + IW'(pos_ff);
   assign last_pos = IW'(pos_ff) + IW'(1) + IW'(fmax_ff);
   assign rsum     = IW'(rep_rdata[OFF_W-1:0]) + IW'(pos_ff);
   assign rel_ok   = (fhdr_ff.mode != MODE_OCC_REL) || (rsum >= IW'(REL_BIAS));
   assign ridx     = (fhdr_ff.mode == MODE_OCC_REL) ? (rsum - IW'(REL_BIAS))
                                                    : IW'(rep_rdata[OFF_W-1:0]);
   assign pkt_byte = inr_ff ? pkt_rdata : '0;

   assign ent_raddr = {slot_ff[FW-1:0], k_ff[EW-1:0]};
   assign ent_waddr = {slot_ff[FW-1:0], k_ff[EW-1:0]};
   assign ent_wdata = {val_ff, off_ff};
   assign pkt_raddr = (state_ff == ST_S_PKT) ? sidx[PW-1:0] : off_ff[PW-1:0];
   assign pkt_waddr = (state_ff == ST_R_WR) ? ridx[PW-1:0] : off_ff[PW-1:0];
   assign pkt_wdata = (state_ff == ST_R_WR) ? rep_rdata[EN_W-1 -: VAL_W] : val_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      fi_in        = fi_ff;
      nhdr_in      = nhdr_ff;
      off_in       = off_ff;
      val_in       = val_ff;
      len_in       = len_ff;
      active_in    = active_ff;
      slot_in      = slot_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      sval_in      = sval_ff;
      inr_in       = inr_ff;
      fhdr_in      = fhdr_ff;
      fmax_in      = fmax_ff;
      fnsrc_in     = fnsrc_ff;
      fnrep_in     = fnrep_ff;
      rd_in        = rd_ff;
      mod_in       = mod_ff;
      hit_in       = hit_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      fvalid_in    = fvalid_ff;
      ft_we        = 1'b0;
      ft_wdata     = {fhdr_ff, new_max, fnrep_ff, fnsrc_ff};
      src_we       = 1'b0;
      rep_we       = 1'b0;
      pkt_we       = 1'b0;

      if (csr_we) begin
         active_in = csr_wdata;
      end
      // Drop the result once taken.
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = cmd_type'(req_tuser);
               fi_in   = f_fi;
               nhdr_in = '{enabled: f_en, mode: mode_type'(f_mode), func: f_func,
                           actions: f_act, len_min: f_lmin, len_max: f_lmax};
               off_in  = f_off;
               val_in  = f_val;
               len_in  = f_len;
               slot_in = SW'(f_fi);
               rd_in   = '0;
               mod_in  = 1'b0;
               hit_in  = 1'b0;
               rej_in  = 1'b0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_DONE;
            k_in     = '0;
            unique case (cmd_ff)
               CMD_HEADER: begin
                  if (fi_ok) begin
                     ft_we    = 1'b1;
                     ft_wdata = {nhdr_ff, {OFF_W{1'b0}}, {CW{1'b0}}, {CW{1'b0}}};
                     fvalid_in[slot_ff[FW-1:0]] = 1'b1;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
               CMD_ADD_SRC, CMD_ADD_REP: begin
                  if (fi_ok) begin
                     state_in = ST_ADD_RD;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
               CMD_WRITE: begin
                  if (off_ok) begin
                     pkt_we = 1'b1;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
               CMD_READ: begin
                  if (off_ok) begin
                     state_in = ST_BYTE_RD;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
               CMD_APPLY: begin
                  slot_in  = '0;
                  state_in = ST_WALK;
               end
               CMD_CHECK: begin
                  slot_in = '0;
                  if (act_ok) begin
                     state_in = ST_WALK;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_ADD_RD: begin
            {fhdr_in, fmax_in, fnrep_in, fnsrc_in} = ft_rd;
            state_in = ST_ADD_SCAN;
         end
         ST_ADD_SCAN: begin
            if (k_ff == cnt) begin
               state_in = ST_DONE;
               if (cnt >= CW'(MAX_ENTRIES)) begin
                  rej_in = 1'b1;
               end else begin
                  ft_we = 1'b1;
                  fvalid_in[slot_ff[FW-1:0]] = 1'b1;
                  if (cmd_ff == CMD_ADD_SRC) begin
                     src_we   = 1'b1;
                     ft_wdata = {fhdr_ff, new_max, fnrep_ff, fnsrc_ff + 1'b1};
                  end else begin
                     rep_we   = 1'b1;
                     ft_wdata = {fhdr_ff, fmax_ff, fnrep_ff + 1'b1, fnsrc_ff};
                  end
               end
            end else begin
               state_in = ST_ADD_CHK;
            end
         end
         ST_ADD_CHK: begin
            // A duplicate offset leaves the list as it is.
            if (chk_off == off_ff) begin
               state_in = ST_DONE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_ADD_SCAN;
            end
         end
         ST_BYTE_RD: begin
            rd_in    = pkt_rdata;
            state_in = ST_DONE;
         end
         ST_WALK: begin
            if (LW'(slot_ff) >= lim) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            {fhdr_in, fmax_in, fnrep_in, fnsrc_in} = ft_rd;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            k_in   = '0;
            pos_in = '0;
            if (skip) begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_WALK;
            end else if (fhdr_ff.mode == MODE_BAD) begin
               rej_in   = 1'b1;
               slot_in  = slot_ff + 1'b1;
               state_in = ST_WALK;
            end else if ((fhdr_ff.mode != MODE_FIXED) && !(fmax_ff < len16)) begin
               // Sliding search over an empty packet finds nothing.
               slot_in  = slot_ff + 1'b1;
               state_in = ST_WALK;
            end else begin
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: begin
            if (k_ff == fnsrc_ff) begin
               if (cmd_ff == CMD_CHECK) begin
                  hit_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  k_in     = '0;
                  state_in = ST_R_RD;
               end
            end else begin
               state_in = ST_S_PKT;
            end
         end
         ST_S_PKT: begin
            sval_in  = src_rdata[EN_W-1 -: VAL_W];
            inr_in   = sidx < IW'(MAX_PACKET);
            state_in = ST_S_CMP;
         end
         ST_S_CMP: begin
            if (pkt_byte == sval_ff) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_S_RD;
            end else if ((fhdr_ff.mode == MODE_FIXED) || (last_pos >= IW'(len_ff))) begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_WALK;
            end else begin
               pos_in   = pos_ff + 1'b1;
               k_in     = '0;
               state_in = ST_S_RD;
            end
         end
         ST_R_RD: begin
            if (k_ff == fnrep_ff) begin
               mod_in   = 1'b1;
               slot_in  = slot_ff + 1'b1;
               state_in = ST_WALK;
            end else begin
               state_in = ST_R_WR;
            end
         end
         ST_R_WR: begin
            // Skip edits that fall outside the packet.
            pkt_we   = rel_ok && (ridx < IW'(len_ff)) && (ridx < IW'(MAX_PACKET));
            k_in     = k_ff + 1'b1;
            state_in = ST_R_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, rej_ff, hit_ff, mod_ff, rd_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         fvalid_ff    <= '0;
         ft_rvalid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         fvalid_ff    <= fvalid_in;
         ft_rvalid_ff <= fvalid_ff[slot_ff[FW-1:0]];
      end
      cmd_ff      <= cmd_in;
      fi_ff       <= fi_in;
      nhdr_ff     <= nhdr_in;
      off_ff      <= off_in;
      val_ff      <= val_in;
      len_ff      <= len_in;
      slot_ff     <= slot_in;
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      sval_ff     <= sval_in;
      inr_ff      <= inr_in;
      fhdr_ff     <= fhdr_in;
      fmax_ff     <= fmax_in;
      fnsrc_ff    <= fnsrc_in;
      fnrep_ff    <= fnrep_in;
      rd_ff       <= rd_in;
      mod_ff      <= mod_in;
      hit_ff      <= hit_in;
      rej_ff      <= rej_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Filter table: header, largest search offset and both list counts per slot.
   pomr_ram #(.WIDTH(FT_W), .DEPTH(2**FW)) u_filter_ram (
      .clock (clock),
      .we    (ft_we),
      .waddr (slot_ff[FW-1:0]),
      .wdata (ft_wdata),
      .raddr (slot_ff[FW-1:0]),
      .rdata (ft_rdata)
   );

   pomr_ram #(.WIDTH(EN_W), .DEPTH(2**(FW+EW))) u_search_ram (
      .clock (clock),
      .we    (src_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (src_rdata)
   );

   pomr_ram #(.WIDTH(EN_W), .DEPTH(2**(FW+EW))) u_replace_ram (
      .clock (clock),
      .we    (rep_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (rep_rdata)
   );

   pomr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PACKET)) u_packet_ram (
      .clock (clock),
      .we    (pkt_we),
      .waddr (pkt_waddr),
      .wdata (pkt_wdata),
      .raddr (pkt_raddr),
      .rdata (pkt_rdata)
   );

endmodule

// ----- rtl/pomr_checker.sv -----
// Port-level checks for packet_offset_match_rewrite, attached by bind.
// Depends on pomr_pkg.
module pomr_checker
   import pomr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while one is in work");

   a_mod_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[8] && rsp_tdata[9]))
      else $error("modified and action_hit in one result");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:11] == 5'b0)
      else $error("result pad bits not zero");

endmodule

bind packet_offset_match_rewrite pomr_checker u_pomr_checker (.*);

// ----- tb/packet_offset_match_rewrite_tb.sv -----
// Self-checking testbench for packet_offset_match_rewrite: directed table, then random traffic.
// Depends on pomr_pkg and the rtl top level; beats are checked by predictor or literal value.
`timescale 1ns / 100ps

module packet_offset_match_rewrite_tb;
   import pomr_pkg::*;

   localparam int NFILT        = 16;
   localparam int PKT_BYTES    = 2048;
   localparam int PREFILL      = 160;
   localparam int LIST_DEPTH   = 256;
   localparam int IDLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS = 260;

   // One command beat, unpacked
   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [FIDX_W-1:0] fidx;
      logic              en;
      logic [1:0]        mode;
      logic [FUNC_W-1:0] func;
      logic [ACT_W-1:0]  act;
      logic [OFF_W-1:0]  len_min;
      logic [OFF_W-1:0]  len_max;
      logic [OFF_W-1:0]  off;
      logic [VAL_W-1:0]  val;
      logic [LEN_W-1:0]  len;
   } cmd_beat_t;

   typedef struct {
      logic [7:0] rd;
      logic       mod;
      logic       hit;
      logic       rej;
   } rsp_beat_t;

   // Directed row: a beat plus an optional literal expectation
   typedef struct {
      cmd_beat_t beat;
      bit        lit;
      rsp_beat_t want;
   } dir_row_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [CMD_W-1:0]      req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_W-1:0]      csr_wdata;

   packet_offset_match_rewrite u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Shadow state of the engine
   // ---------------------------------------------------------------------
   hdr_type          shadow_hdr   [NFILT];
   logic [OFF_W-1:0] srch_off     [NFILT][LIST_DEPTH];
   logic [7:0]       srch_val     [NFILT][LIST_DEPTH];
   logic [OFF_W-1:0] repl_off     [NFILT][LIST_DEPTH];
   logic [7:0]       repl_val     [NFILT][LIST_DEPTH];
   int               srch_cnt     [NFILT];
   int               repl_cnt     [NFILT];
   logic [OFF_W-1:0] srch_max_off [NFILT];
   logic [7:0]       pkt_shadow   [PKT_BYTES];
   int               slots_active;

   rsp_beat_t pending_rsp [$];
   bit        failed;
   int        idle_cycles;
   int        n_beats, n_mod, n_hit, n_rej;
   int        n_cmd [8];

   function automatic logic [7:0] pkt_byte(int idx);
      return (idx < PKT_BYTES) ? pkt_shadow[idx] : 8'h00;
   endfunction

   // Sorted insert; duplicate offsets are dropped silently. Returns 1 when full.
   function automatic bit list_insert(bit is_srch, int f, logic [OFF_W-1:0] o,
                                      logic [7:0] v);
      int n;
      int k;
      n = is_srch ? srch_cnt[f] : repl_cnt[f];
      for (k = 0; k < n; k++) begin
         if ((is_srch ? srch_off[f][k] : repl_off[f][k]) == o) return 1'b0;
      end
      if (n >= LIST_DEPTH) return 1'b1;
      k = n;
      if (is_srch) begin
         while (k > 0 && srch_off[f][k-1] > o) begin
            srch_off[f][k] = srch_off[f][k-1];
            srch_val[f][k] = srch_val[f][k-1];
            k--;
         end
         srch_off[f][k] = o;
         srch_val[f][k] = v;
         srch_cnt[f]    = n + 1;
      end else begin
         while (k > 0 && repl_off[f][k-1] > o) begin
            repl_off[f][k] = repl_off[f][k-1];
            repl_val[f][k] = repl_val[f][k-1];
            k--;
         end
         repl_off[f][k] = o;
         repl_val[f][k] = v;
         repl_cnt[f]    = n + 1;
      end
      return 1'b0;
   endfunction

   function automatic bit slot_qualifies(int f, int len, logic [FUNC_W-1:0] fn);
      if (!shadow_hdr[f].enabled) return 1'b0;
      if (shadow_hdr[f].len_max != 0 &&
          (len < shadow_hdr[f].len_min || len > shadow_hdr[f].len_max)) return 1'b0;
      if ((shadow_hdr[f].func & fn) == 0) return 1'b0;
      if (srch_cnt[f] != 0 && srch_max_off[f] >= len) return 1'b0;
      return 1'b1;
   endfunction

   // 0 no match, 1 match, 2 bad mode; pos is the occurrence start
   function automatic int pattern_match(int f, int len, output int pos);
      int  i;
      int  k;
      int  idx;
      bit  miss;
      pos = 0;
      if (shadow_hdr[f].mode == MODE_FIXED) begin
         for (k = 0; k < srch_cnt[f]; k++)
            if (pkt_byte(srch_off[f][k]) != srch_val[f][k]) return 0;
         return 1;
      end
      if (shadow_hdr[f].mode == MODE_BAD) return 2;
      for (i = 0; i < len; i++) begin
         miss = 1'b0;
         for (k = 0; k < srch_cnt[f]; k++) begin
            idx = int'(srch_off[f][k]) + i;
            if (idx + 1 > len) return 0;
            if (pkt_byte(idx) != srch_val[f][k]) begin
               miss = 1'b1;
               break;
            end
         end
         if (!miss) begin
            pos = i;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic rsp_beat_t engine_step(cmd_beat_t b);
      rsp_beat_t r;
      int        f;
      int        k;
      int        pos;
      int        m;
      int        idx;
      int        lim;
      int        fi;
      r   = '{rd: 8'h00, mod: 1'b0, hit: 1'b0, rej: 1'b0};
      fi  = b.fidx;
      lim = (slots_active < NFILT) ? slots_active : NFILT;
      case (b.cmd)
         CMD_HEADER: begin
            if (fi >= NFILT) begin
               r.rej = 1'b1;
            end else begin
               shadow_hdr[fi] = '{enabled: b.en, mode: mode_type'(b.mode), func: b.func,
                                  actions: b.act, len_min: b.len_min, len_max: b.len_max};
               srch_cnt[fi]     = 0;
               repl_cnt[fi]     = 0;
               srch_max_off[fi] = '0;
            end
         end
         CMD_ADD_SRC: begin
            if (fi >= NFILT) begin
               r.rej = 1'b1;
            end else begin
               r.rej = list_insert(1'b1, fi, b.off, b.val);
               if (srch_cnt[fi] != 0) srch_max_off[fi] = srch_off[fi][srch_cnt[fi]-1];
            end
         end
         CMD_ADD_REP: begin
            if (fi >= NFILT) r.rej = 1'b1;
            else r.rej = list_insert(1'b0, fi, b.off, b.val);
         end
         CMD_WRITE: begin
            if (b.off >= PKT_BYTES) r.rej = 1'b1;
            else pkt_shadow[b.off] = b.val;
         end
         CMD_APPLY: begin
            for (f = 0; f < lim; f++) begin
               if (repl_cnt[f] == 0 || !slot_qualifies(f, b.len, b.func)) continue;
               m = pattern_match(f, b.len, pos);
               if (m == 2) begin
                  r.rej = 1'b1;
                  continue;
               end
               if (m == 0) continue;
               for (k = 0; k < repl_cnt[f]; k++) begin
                  if (shadow_hdr[f].mode == MODE_OCC_REL) begin
                     idx = int'(repl_off[f][k]) + pos;
                     if (idx < REL_BIAS) continue;
                     idx -= REL_BIAS;
                  end else begin
                     idx = repl_off[f][k];
                  end
                  // an edit at index length or beyond is skipped
                  if (idx < b.len && idx < PKT_BYTES) pkt_shadow[idx] = repl_val[f][k];
               end
               r.mod = 1'b1;
            end
         end
         CMD_CHECK: begin
            if (!(b.act inside {4'd1, 4'd2, 4'd4, 4'd8})) begin
               r.rej = 1'b1;
            end else begin
               for (f = 0; f < lim; f++) begin
                  if ((shadow_hdr[f].actions & b.act) == 0) continue;
                  if (srch_cnt[f] == 0 || !slot_qualifies(f, b.len, b.func)) continue;
                  m = pattern_match(f, b.len, pos);
                  if (m == 2) begin
                     r.rej = 1'b1;
                     continue;
                  end
                  if (m == 1) begin
                     r.hit = 1'b1;
                     break;
                  end
               end
            end
         end
         CMD_READ: begin
            if (b.off >= PKT_BYTES) r.rej = 1'b1;
            else r.rd = pkt_shadow[b.off];
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset, watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_rsp.size());
            $display("packet_offset_match_rewrite_tb: FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side: stall pattern and checker
   // ---------------------------------------------------------------------
   int stall_cyc;

   always @(posedge clock) begin
      stall_cyc <= stall_cyc + 1;
      // rotate between open, random and periodic stalls
      case ((stall_cyc / 96) % 3)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 99) < 55);
         default: rsp_tready <= ((stall_cyc % 7) > 2);
      endcase
   end

   always @(posedge clock) begin
      rsp_beat_t got;
      rsp_beat_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rd: rsp_tdata[7:0], mod: rsp_tdata[8], hit: rsp_tdata[9],
                 rej: rsp_tdata[10]};
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, rsp_tdata);
            failed = 1'b1;
         end else begin
            want = pending_rsp.pop_front();
            if (got.rd !== want.rd) begin
               $display("%0t: read_value expected %h actual %h", $time, want.rd, got.rd);
               failed = 1'b1;
            end
            if (got.mod !== want.mod) begin
               $display("%0t: modified expected %b actual %b", $time, want.mod, got.mod);
               failed = 1'b1;
            end
            if (got.hit !== want.hit) begin
               $display("%0t: action_hit expected %b actual %b", $time, want.hit, got.hit);
               failed = 1'b1;
            end
            if (got.rej !== want.rej) begin
               $display("%0t: rejected expected %b actual %b", $time, want.rej, got.rej);
               failed = 1'b1;
            end
            n_mod += got.mod;
            n_hit += got.hit;
            n_rej += got.rej;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Command side
   // ---------------------------------------------------------------------
   int  burst_left;
   bit  no_gaps;

   // Drive one beat, hold it until taken, then predict and queue the result.
   task automatic send_beat(cmd_beat_t b, bit lit = 1'b0, rsp_beat_t want = '{default: 0});
      rsp_beat_t pred;
      int        gap;
      req_tuser  <= b.cmd;
      req_tdata  <= {1'b0, b.len, b.val, b.off, b.len_max, b.len_min, b.act, b.func,
                     b.mode, b.en, b.fidx};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = engine_step(b);
      pending_rsp.push_back(lit ? want : pred);
      n_beats++;
      n_cmd[b.cmd]++;
      // bursts of random length, then a random gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 16);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_active_filters(logic [CSR_W-1:0] v);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we       <= 1'b0;
      slots_active = v;
   endtask

   function automatic cmd_beat_t zero_beat(logic [CMD_W-1:0] c);
      cmd_beat_t b;
      b     = '{default: 0};
      b.cmd = c;
      return b;
   endfunction

   function automatic cmd_beat_t header_beat(int f, bit en, logic [1:0] md,
                                             logic [FUNC_W-1:0] fn, logic [ACT_W-1:0] a,
                                             logic [OFF_W-1:0] lmin, logic [OFF_W-1:0] lmax);
      cmd_beat_t b;
      b         = zero_beat(CMD_HEADER);
      b.fidx    = f;
      b.en      = en;
      b.mode    = md;
      b.func    = fn;
      b.act     = a;
      b.len_min = lmin;
      b.len_max = lmax;
      return b;
   endfunction

   function automatic cmd_beat_t entry_beat(logic [CMD_W-1:0] c, int f,
                                            logic [OFF_W-1:0] o, logic [7:0] v);
      cmd_beat_t b;
      b      = zero_beat(c);
      b.fidx = f;
      b.off  = o;
      b.val  = v;
      return b;
   endfunction

   function automatic cmd_beat_t query_beat(logic [CMD_W-1:0] c, logic [FUNC_W-1:0] fn,
                                            logic [ACT_W-1:0] a, logic [LEN_W-1:0] l);
      cmd_beat_t b;
      b      = zero_beat(c);
      b.func = fn;
      b.act  = a;
      b.len  = l;
      return b;
   endfunction

   // Random beat, biased so searches mostly match the current packet bytes.
   // Reads and searched bytes stay below PREFILL or beyond the store.
   function automatic cmd_beat_t random_beat();
      cmd_beat_t b;
      int        pick;
      int        f;
      int        shift;
      b    = zero_beat(CMD_HEADER);
      pick = $urandom_range(0, 99);
      f    = $urandom_range(0, NFILT - 1);
      b.fidx = f;
      if (pick < 12) begin
         b.cmd     = CMD_HEADER;
         b.en      = ($urandom_range(0, 9) != 0);
         b.mode    = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
         b.func    = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
         b.act     = 4'($urandom);
         b.len_max = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
         b.len_min = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
         if ($urandom_range(0, 2) == 0) b.len_max = 16'($urandom_range(100, 300));
      end else if (pick < 34) begin
         b.cmd = CMD_ADD_SRC;
         b.off = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(PKT_BYTES, 65535))
                                              : 16'($urandom_range(0, 40));
         shift = (shadow_hdr[f].mode == MODE_FIXED) ? 0 : $urandom_range(0, 20);
         b.val = ($urandom_range(0, 9) < 7) ? pkt_byte(int'(b.off) + shift) : 8'($urandom);
      end else if (pick < 50) begin
         b.cmd = CMD_ADD_REP;
         if (shadow_hdr[f].mode == MODE_OCC_REL) b.off = 16'($urandom_range(220, 330));
         else if ($urandom_range(0, 19) == 0) b.off = 16'($urandom);
         else b.off = 16'($urandom_range(0, 80));
         b.val = 8'($urandom);
      end else if (pick < 62) begin
         b.cmd = CMD_WRITE;
         b.off = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
         b.val = 8'($urandom);
      end else if (pick < 90) begin
         b.cmd  = (pick < 76) ? CMD_APPLY : CMD_CHECK;
         b.func = ($urandom_range(0, 1) == 0) ? 16'($urandom) : (16'd1 << $urandom_range(0, 15));
         b.act  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : (4'd1 << $urandom_range(0, 3));
         if ($urandom_range(0, 29) == 0)
            b.len = ($urandom_range(0, 1) == 0) ? 12'd0 : 12'(PREFILL);
         else
            b.len = 12'($urandom_range(20, PREFILL));
      end else if (pick < 97) begin
         b.cmd = CMD_READ;
         b.off = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(PKT_BYTES, 65535))
                                             : 16'($urandom_range(0, PREFILL - 1));
      end else begin
         // unused command code, other fields noise
         b.cmd     = 3'd7;
         b.off     = 16'($urandom);
         b.val     = 8'($urandom);
         b.len_min = 16'($urandom);
      end
      return b;
   endfunction

   dir_row_t dir_rows [$];

   task automatic add_row(cmd_beat_t b, bit lit = 1'b0, rsp_beat_t want = '{default: 0});
      dir_rows.push_back('{beat: b, lit: lit, want: want});
   endtask

   initial begin
      int        i;
      int        ph;
      rsp_beat_t none;
      rsp_beat_t rej;
      none = '{rd: 8'h00, mod: 1'b0, hit: 1'b0, rej: 1'b0};
      rej  = '{rd: 8'h00, mod: 1'b0, hit: 1'b0, rej: 1'b1};
      burst_left  = 0;
      no_gaps     = 1'b0;
      n_beats = 0;
      foreach (n_cmd[i]) n_cmd[i] = 0;
      for (i = 0; i < NFILT; i++) begin
         shadow_hdr[i]   = '0;
         srch_cnt[i]     = 0;
         repl_cnt[i]     = 0;
         srch_max_off[i] = '0;
      end
      slots_active = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the low part of the packet store; reads and searches stay inside it
      no_gaps = 1'b1;
      for (i = 0; i < PREFILL; i++)
         send_beat(entry_beat(CMD_WRITE, 0, 16'(i), 8'($urandom)));
      no_gaps = 1'b0;
      set_active_filters(5'd16);

      // Directed: store edges, duplicates, bad mode, bad action, unused code
      add_row(entry_beat(CMD_WRITE, 0, 16'd0, 8'hAA), 1'b1, none);
      add_row(entry_beat(CMD_WRITE, 0, 16'd1, 8'h55), 1'b1, none);
      add_row(entry_beat(CMD_WRITE, 0, 16'd2047, 8'hFF), 1'b1, none);
      add_row(entry_beat(CMD_WRITE, 0, 16'd2048, 8'h11), 1'b1, rej);
      add_row(entry_beat(CMD_WRITE, 0, 16'hFFFF, 8'hFF), 1'b1, rej);
      add_row(entry_beat(CMD_READ, 0, 16'd0, 8'h00), 1'b1, '{8'hAA, 1'b0, 1'b0, 1'b0});
      add_row(entry_beat(CMD_READ, 0, 16'd2047, 8'h00), 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0});
      add_row(entry_beat(CMD_READ, 0, 16'hFFFF, 8'h00), 1'b1, rej);
      add_row(query_beat(3'd7, 16'hFFFF, 4'hF, 12'd2048), 1'b1, none);
      add_row(header_beat(0, 1'b1, MODE_FIXED, 16'hFFFF, 4'd1, 16'd0, 16'd0), 1'b1, none);
      add_row(entry_beat(CMD_ADD_SRC, 0, 16'd0, 8'hAA), 1'b1, none);
      add_row(entry_beat(CMD_ADD_SRC, 0, 16'd0, 8'h00));   // duplicate offset, ignored
      add_row(entry_beat(CMD_ADD_SRC, 0, 16'd1, 8'h55));
      add_row(entry_beat(CMD_ADD_REP, 0, 16'd1, 8'h77));
      add_row(entry_beat(CMD_ADD_REP, 0, 16'd2, 8'h33));   // at index length: skipped
      add_row(query_beat(CMD_CHECK, 16'h0001, 4'd1, 12'd2));
      add_row(query_beat(CMD_APPLY, 16'h8000, 4'd0, 12'd2));
      add_row(entry_beat(CMD_READ, 0, 16'd1, 8'h00));
      add_row(header_beat(1, 1'b1, MODE_BAD, 16'hFFFF, 4'd8, 16'hFFFF, 16'hFFFF));
      add_row(header_beat(2, 1'b1, MODE_BAD, 16'hFFFF, 4'd2, 16'd0, 16'd0));
      add_row(entry_beat(CMD_ADD_SRC, 2, 16'd0, 8'h00));
      add_row(query_beat(CMD_CHECK, 16'hFFFF, 4'd2, 12'd4));
      add_row(query_beat(CMD_CHECK, 16'hFFFF, 4'd3, 12'd40), 1'b1, rej);
      add_row(query_beat(CMD_CHECK, 16'hFFFF, 4'd0, 12'd40), 1'b1, rej);
      add_row(query_beat(CMD_APPLY, 16'hFFFF, 4'd0, 12'd2048));
      foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].lit, dir_rows[i].want);

      // Full search list on the top slot, a duplicate on the full list, then clear it
      send_beat(header_beat(NFILT - 1, 1'b0, MODE_FIXED, 16'h0, 4'h0, 16'd0, 16'd0));
      for (i = 0; i <= LIST_DEPTH; i++)
         send_beat(entry_beat(CMD_ADD_SRC, NFILT - 1, 16'(i * 3), 8'($urandom)));
      send_beat(entry_beat(CMD_ADD_SRC, NFILT - 1, 16'd0, 8'($urandom)));
      send_beat(header_beat(NFILT - 1, 1'b0, MODE_FIXED, 16'h0, 4'h0, 16'd0, 16'd0));

      // Random phases, each under its own slot count; extremes included
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       set_active_filters(5'd16);
            1:       set_active_filters(5'd31);
            2:       set_active_filters(5'd0);
            3:       set_active_filters(5'd5);
            default: set_active_filters(5'($urandom_range(1, 15)));
         endcase
         no_gaps = (ph == 3);
         for (i = 0; i < RANDOM_ITEMS / 5; i++) send_beat(random_beat());
      end

      drain_results();
      $display("Covered %0d beats: %0d header, %0d search, %0d replace, %0d write,",
               n_beats, n_cmd[0], n_cmd[1], n_cmd[2], n_cmd[3]);
      $display("  %0d apply, %0d check, %0d read; %0d edits, %0d action hits, %0d rejects",
               n_cmd[4], n_cmd[5], n_cmd[6], n_mod, n_hit, n_rej);
      if (!failed) begin
         $display("packet_offset_match_rewrite_tb: PASS");
      end else begin
         $display("packet_offset_match_rewrite_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pomr_pkg.sv
rtl/pomr_ram.sv
rtl/packet_offset_match_rewrite.sv
rtl/pomr_checker.sv
tb/packet_offset_match_rewrite_tb.sv
